@@ hdl/tcsni_pkg.sv @@
// Shared types and constants for the TLS ClientHello server-name extractor.
package tcsni_pkg;

   // Widths of the position and parse-length state
   localparam int POS_WIDTH        = 16;
   localparam int FAR_POS_WIDTH    = 17;
   localparam int LEN_WIDTH        = 16;
   localparam int NAME_WIDTH       = 8;

   // Packet size limit default
   localparam int MAX_PACKET_BYTES_DEFAULT = 65535;

   // Configuration register map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_PACKET_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NAME_LENGTH_LIMIT = 1'd1;

   // Register reset values
   localparam logic [15:0] MIN_PACKET_LENGTH_RESET = 16'd100;
   localparam logic [7:0]  NAME_LENGTH_LIMIT_RESET = 8'd100;

   // Protocol constants
   localparam logic [7:0]  TLS_HANDSHAKE_TYPE   = 8'h16;
   localparam logic [7:0]  TLS_MAJOR_VERSION    = 8'd3;
   localparam logic [7:0]  CLIENT_HELLO_TYPE    = 8'd1;
   localparam logic [7:0]  RECORD_HEADER_BYTES  = 8'd5;
   localparam logic [FAR_POS_WIDTH-1:0] SESSION_ID_POS = 17'd43;
   localparam logic [FAR_POS_WIDTH-1:0] SNI_ENTRY_SKIP = 17'd5;

   // One input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_word_type;

   // One result word
   typedef struct packed {
      logic                  name_valid;
      logic [7:0]            name_char;
      logic [NAME_WIDTH-1:0] name_index;
      logic                  done_res;
      logic                  found;
      logic [NAME_WIDTH-1:0] name_length;
   } rsp_word_type;

endpackage

@@ hdl/tcsni_in_stage.sv @@
// Input register stage: captures one packet byte and holds it until it is parsed.
module tcsni_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcsni_pkg::in_word_type req_word,
   input  logic                   out_free,
   output logic                   word_valid,
   output tcsni_pkg::in_word_type word
);

   logic                   valid_ff;
   logic                   valid_in;
   tcsni_pkg::in_word_type word_ff;
   logic                   take;
   logic                   step;

   // Parse the held word whenever the result register can take its result
   assign step      = valid_ff && out_free;
   assign req_stall = valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   // Hold the word until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

@@ hdl/tcsni_parser.sv @@
// Byte-at-a-time ClientHello parser: parse state, configuration registers, result word.
module tcsni_parser #(
   parameter int MAX_PACKET_BYTES = tcsni_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  tcsni_pkg::in_word_type                 word,
   input  logic                                   csr_write_enable,
   input  logic [tcsni_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tcsni_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output tcsni_pkg::rsp_word_type                result
);

   typedef enum logic [4:0] {
      PH_HDR, PH_SID, PH_CS_HI, PH_CS_LO, PH_CM, PH_EXL_HI, PH_EXL_LO,
      PH_EXT_T0, PH_EXT_T1, PH_EXT_L2, PH_EXT_L3, PH_SNI_HT, PH_SNI_LHI,
      PH_SNI_LLO, PH_NAME, PH_FOUND, PH_FAIL
   } phase_type;

   localparam int PW = tcsni_pkg::POS_WIDTH;
   localparam int FW = tcsni_pkg::FAR_POS_WIDTH;
   localparam int LW = tcsni_pkg::LEN_WIDTH;
   localparam int NW = tcsni_pkg::NAME_WIDTH;

   // Configuration registers
   logic [15:0] min_packet_length_ff;
   logic [7:0]  name_length_limit_ff;

   // Parse state
   phase_type       phase_ff, phase_in;
   logic [PW-1:0]   position_ff;
   logic [FW-1:0]   record_end_ff, record_end_in;
   logic [LW-1:0]   field_length_ff, field_length_in;
   logic [FW-1:0]   next_pos_ff, next_pos_in;
   logic [NW-1:0]   name_total_ff, name_total_in;
   logic [NW-1:0]   name_count_ff, name_count_in;
   logic            header_ok_ff, header_ok_in;

   // Datapath terms
   logic [7:0]    b;
   logic [FW-1:0] pos_ext;
   logic [LW-1:0] len16;
   logic [FW-1:0] after_byte;
   logic [FW-1:0] after_len;
   logic [FW-1:0] ext_end;
   logic [NW-1:0] count_next;
   logic          overflow;
   logic          long_enough;
   tcsni_pkg::rsp_word_type result_in;

   assign b           = word.data_byte;
   assign pos_ext     = {1'b0, position_ff};
   assign len16       = {field_length_ff[LW-1:8], b};
   assign after_byte  = pos_ext + FW'(1) + {{(FW-8){1'b0}}, b};
   assign after_len   = pos_ext + FW'(1) + {{(FW-LW){1'b0}}, len16};
   assign ext_end     = (pos_ext - FW'(1)) + {{(FW-LW){1'b0}}, len16};
   assign count_next  = name_count_ff + NW'(1);
   assign overflow    = position_ff >= PW'(MAX_PACKET_BYTES);
   assign long_enough = (pos_ext + FW'(1)) > {1'b0, min_packet_length_ff};

   // Next parse state for the byte at the current position
   always_comb begin
      phase_in        = phase_ff;
      record_end_in   = record_end_ff;
      field_length_in = field_length_ff;
      next_pos_in     = next_pos_ff;
      name_total_in   = name_total_ff;
      name_count_in   = name_count_ff;
      header_ok_in    = header_ok_ff;
      result_in       = '0;

      if (overflow) begin
         phase_in = PH_FAIL;
      end else if (phase_ff == PH_HDR) begin
         // Record header and handshake type
         priority if (position_ff == PW'(0)) begin
            header_ok_in = (b == tcsni_pkg::TLS_HANDSHAKE_TYPE);
         end else if (position_ff == PW'(1)) begin
            header_ok_in = header_ok_ff && (b == tcsni_pkg::TLS_MAJOR_VERSION);
         end else if (position_ff == PW'(3)) begin
            field_length_in = {b, 8'd0};
         end else if (position_ff == PW'(4)) begin
            record_end_in = {1'b0, field_length_ff[LW-1:8], b}
                            + FW'(tcsni_pkg::RECORD_HEADER_BYTES);
         end else if (position_ff == PW'(5)) begin
            if (header_ok_ff && b == tcsni_pkg::CLIENT_HELLO_TYPE &&
                record_end_ff > tcsni_pkg::SESSION_ID_POS) begin
               next_pos_in = tcsni_pkg::SESSION_ID_POS;
               phase_in    = PH_SID;
            end else begin
               phase_in = PH_FAIL;
            end
         end else begin
            phase_in = phase_ff;
         end
      end else if (phase_ff < PH_FOUND && pos_ext == next_pos_ff) begin
         unique case (phase_ff)
            PH_SID: begin
               if (after_byte < record_end_ff) begin
                  next_pos_in = after_byte;
                  phase_in    = PH_CS_HI;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_CS_HI, PH_EXL_HI, PH_EXT_L2, PH_SNI_LHI: begin
               field_length_in = {b, 8'd0};
               next_pos_in     = pos_ext + FW'(1);
               phase_in        = phase_type'(phase_ff + 5'd1);
            end
            PH_CS_LO: begin
               if (len16 == '0) begin
                  phase_in = PH_FAIL;
               end else if (after_len < record_end_ff) begin
                  next_pos_in = after_len;
                  phase_in    = PH_CM;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_CM: begin
               if (b == 8'd0) begin
                  phase_in = PH_FAIL;
               end else if (after_byte < record_end_ff) begin
                  next_pos_in = after_byte;
                  phase_in    = PH_EXL_HI;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_EXL_LO: begin
               // Clip the extension end from the length field's own position
               if (ext_end < record_end_ff) begin
                  record_end_in = ext_end;
               end
               if (pos_ext + FW'(1) < record_end_in) begin
                  next_pos_in = pos_ext + FW'(1);
                  phase_in    = PH_EXT_T0;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_EXT_T0: begin
               field_length_in = {8'd0, b};
               next_pos_in     = pos_ext + FW'(1);
               phase_in        = PH_EXT_T1;
            end
            PH_EXT_T1: begin
               if (field_length_ff == '0 && b == 8'd0) begin
                  next_pos_in = pos_ext + tcsni_pkg::SNI_ENTRY_SKIP;
                  phase_in    = PH_SNI_HT;
               end else begin
                  next_pos_in = pos_ext + FW'(1);
                  phase_in    = PH_EXT_L2;
               end
            end
            PH_EXT_L3: begin
               if (after_len < record_end_ff) begin
                  next_pos_in = after_len;
                  phase_in    = PH_EXT_T0;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_SNI_HT: begin
               if (b != 8'd0) begin
                  phase_in = PH_FAIL;
               end else begin
                  next_pos_in = pos_ext + FW'(1);
                  phase_in    = PH_SNI_LHI;
               end
            end
            PH_SNI_LLO: begin
               if (len16 >= {8'd0, name_length_limit_ff}) begin
                  phase_in = PH_FAIL;
               end else begin
                  name_total_in = len16[NW-1:0];
                  name_count_in = '0;
                  next_pos_in   = pos_ext + FW'(1);
                  phase_in      = (len16 == '0) ? PH_FOUND : PH_NAME;
               end
            end
            PH_NAME: begin
               // Emit the name byte tentatively
               result_in.name_valid = 1'b1;
               result_in.name_char  = b;
               result_in.name_index = name_count_ff;
               name_count_in        = count_next;
               if (count_next >= name_total_ff) begin
                  phase_in = PH_FOUND;
               end else begin
                  next_pos_in = pos_ext + FW'(1);
               end
            end
            default: begin
               phase_in = PH_FAIL;
            end
         endcase
      end

      // Verdict on the last byte
      result_in.done_res = word.last_byte;
      if (word.last_byte && !overflow && phase_in == PH_FOUND && long_enough) begin
         result_in.found       = 1'b1;
         result_in.name_length = name_total_in;
      end
   end

   // Hold configuration; advance parse state on each parsed word
   always_ff @(posedge clock) begin
      if (reset) begin
         min_packet_length_ff <= tcsni_pkg::MIN_PACKET_LENGTH_RESET;
         name_length_limit_ff <= tcsni_pkg::NAME_LENGTH_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tcsni_pkg::CSR_MIN_PACKET_LENGTH: min_packet_length_ff <= csr_write_data;
            tcsni_pkg::CSR_NAME_LENGTH_LIMIT: name_length_limit_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end

      if (reset || (step && word.last_byte)) begin
         phase_ff        <= PH_HDR;
         position_ff     <= '0;
         record_end_ff   <= '0;
         field_length_ff <= '0;
         next_pos_ff     <= '0;
         name_total_ff   <= '0;
         name_count_ff   <= '0;
         header_ok_ff    <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         record_end_ff   <= record_end_in;
         field_length_ff <= field_length_in;
         next_pos_ff     <= next_pos_in;
         name_total_ff   <= name_total_in;
         name_count_ff   <= name_count_in;
         header_ok_ff    <= header_ok_in;
         if (!overflow) begin
            position_ff <= position_ff + PW'(1);
         end
      end
   end

   assign result = result_in;

endmodule

@@ hdl/tcsni_out_stage.sv @@
// Result register stage: holds one result word until the consumer takes it.
module tcsni_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  tcsni_pkg::rsp_word_type result,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output tcsni_pkg::rsp_word_type rsp_word,
   output logic                    out_free
);

   logic                    valid_ff;
   tcsni_pkg::rsp_word_type word_ff;

   // Free when empty or when the held word leaves this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load;
      end
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

@@ hdl/tls_client_hello_sni_extract.sv @@
// Top level: TLS ClientHello server-name extractor, one packet byte per word.
// An accepted byte passes through the input register, the parse step and then the
// result register, which holds its result word until the consumer takes it.
// Throughput: one byte per cycle while rsp_stall is low, set by the parse step.
// Reset clears the parse state and sets min_packet_length and
// name_length_limit to 100.
module tls_client_hello_sni_extract #(
   parameter int MAX_PACKET_BYTES = tcsni_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_last_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_name_valid,
   output logic [7:0]                            rsp_name_char,
   output logic [7:0]                            rsp_name_index,
   output logic                                  rsp_done_res,
   output logic                                  rsp_found,
   output logic [7:0]                            rsp_name_length,
   input  logic                                  csr_write_enable,
   input  logic [tcsni_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tcsni_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   tcsni_pkg::in_word_type  req_word;
   tcsni_pkg::in_word_type  word;
   tcsni_pkg::rsp_word_type result;
   tcsni_pkg::rsp_word_type rsp_word;
   logic                    word_valid;
   logic                    out_free;
   logic                    step;

   assign req_word.data_byte = req_data_byte;
   assign req_word.last_byte = req_last_byte;

   // Parse the held byte when the result register has room
   assign step = word_valid && out_free;

   tcsni_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .out_free   (out_free),
      .word_valid (word_valid),
      .word       (word)
   );

   tcsni_parser #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .word             (word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .result           (result)
   );

   tcsni_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .out_free  (out_free)
   );

   assign rsp_name_valid  = rsp_word.name_valid;
   assign rsp_name_char   = rsp_word.name_char;
   assign rsp_name_index  = rsp_word.name_index;
   assign rsp_done_res    = rsp_word.done_res;
   assign rsp_found       = rsp_word.found;
   assign rsp_name_length = rsp_word.name_length;

endmodule
